>>> design/nwcs_pkg.sv
// package for the nibble weight column sums unit: widths, fp4 table, decode and add helpers
`timescale 1ns / 1ps

package nwcs_pkg;

  // reduction length of the weight record, bytes with k at or above it are dropped
  localparam int RED_LEN = 128;

  localparam int OFF_W  = 13;
  localparam int BYTE_W = 8;
  localparam int COL_W  = 7;
  localparam int SUM_W  = 12;
  localparam int WGT_W  = 5;   // decoded weight, -12..12
  localparam int ADDR_W = 6;   // address width, 64 entries per bank
  localparam int DEPTH  = 64;
  localparam int K_W    = 7;
  localparam int KCMP_W = 11;  // wide enough to hold RED_LEN up to 1024

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic {
    FUNC_ACC  = 1'b0,
    FUNC_READ = 1'b1
  } func_t;

  typedef enum logic {
    FMT_INT4 = 1'b0,
    FMT_FP4  = 1'b1
  } num_fmt_t;

  typedef logic signed [WGT_W-1:0] wgt_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  localparam wgt_t FP4_TABLE [16] = '{
    5'sd0,  5'sd1,  5'sd2,  5'sd3,  5'sd4,  5'sd6,  5'sd8,  5'sd12,
    5'sd0, -5'sd1, -5'sd2, -5'sd3, -5'sd4, -5'sd6, -5'sd8, -5'sd12
  };

  localparam sum_t SUM_MAX = sum_t'(2047);
  localparam sum_t SUM_MIN = sum_t'(-2048);

  function automatic wgt_t decode_nibble(input num_fmt_t fmt, input logic [3:0] code);
    wgt_t v;
    if (fmt == FMT_FP4) begin
      v = FP4_TABLE[code];
    end else begin
      v = {code[3], code};
    end
    return v;
  endfunction

  // add one decoded weight to a sum, clamping at the 12-bit limits
  function automatic sum_t sat_add(input sum_t s, input wgt_t w);
    logic signed [SUM_W:0] t;
    logic signed [SUM_W:0] hi_lim;
    logic signed [SUM_W:0] lo_lim;
    sum_t r;
    hi_lim = {SUM_MAX[SUM_W-1], SUM_MAX};
    lo_lim = {SUM_MIN[SUM_W-1], SUM_MIN};
    t = {s[SUM_W-1], s} + {{(SUM_W+1-WGT_W){w[WGT_W-1]}}, w};
    if (t > hi_lim) begin
      r = SUM_MAX;
    end else if (t < lo_lim) begin
      r = SUM_MIN;
    end else begin
      r = t[SUM_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> design/nibble_weight_column_sums_unit.sv
// nibble weight column sums unit: two column-sum banks with read-modify-write and read-and-clear
// a read-and-clear word passes stage one, then its result is registered into the output register on out_
// throughput: one word per cycle; a read word holds off the input while it is in stage one, and any
// word waits while a result word is held by out_tready low
// the sums sit in two 64-entry banks (column bit 4 low / high), one read-modify-write each
// per word, with the previous write forwarded to the next read of the same entry
// reset (rst_n low, synchronous): per-entry valid bits clear, so every sum reads as zero at once
`timescale 1ns / 1ps

module nibble_weight_column_sums_unit
  import nwcs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   cfg_wr_en,
  input  logic                   cfg_wr_data,      // number_format

  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,         // byte_offset, weight_byte, column_select, zeros
  input  logic                   in_tuser,         // func

  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata         // column_index, column_sum, zeros
);

  // input unpacking
  logic [OFF_W-1:0]  in_off;
  logic [BYTE_W-1:0] in_byte;
  logic [COL_W-1:0]  in_sel;
  func_t             in_func;

  assign in_off  = in_tdata[OFF_W-1:0];
  assign in_byte = in_tdata[OFF_W+BYTE_W-1:OFF_W];
  assign in_sel  = in_tdata[OFF_W+BYTE_W+COL_W-1:OFF_W+BYTE_W];
  assign in_func = func_t'(in_tuser);

  num_fmt_t fmt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_INT4;
    end else if (cfg_wr_en) begin
      fmt_r <= num_fmt_t'(cfg_wr_data);
    end
  end

  // stage one registers
  logic              s1_valid_r;
  func_t             s1_func_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic              s1_bank_r;
  logic              s1_kok_r;
  wgt_t              s1_lo_r;
  wgt_t              s1_hi_r;
  logic [COL_W-1:0]  s1_sel_r;

  // output register
  logic              out_valid_r;
  logic [COL_W-1:0]  out_index_r;
  sum_t              out_sum_r;

  logic in_acc;
  assign in_tready = !(s1_valid_r && (s1_func_r == FUNC_READ)) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;

  // k = (row >> 1) * 4 + (offset & 3)
  logic [K_W-1:0]    in_k;
  logic              in_kok;
  logic [ADDR_W-1:0] rd_addr;

  assign in_k    = {in_off[12:8], in_off[1:0]};
  assign in_kok  = {{(KCMP_W-K_W){1'b0}}, in_k} < RED_LEN[KCMP_W-1:0];
  // bank address {b, group, column within 16}
  assign rd_addr = (in_func == FUNC_READ) ? {in_sel[6], in_sel[5], in_sel[3:0]} : in_off[7:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func_r <= in_func;
      s1_addr_r <= rd_addr;
      s1_bank_r <= in_sel[4];
      s1_kok_r  <= in_kok;
      s1_lo_r   <= decode_nibble(fmt_r, in_byte[3:0]);
      s1_hi_r   <= decode_nibble(fmt_r, in_byte[7:4]);
      s1_sel_r  <= in_sel;
    end
  end

  // banks: a holds columns with bit 4 clear (low nibbles), b with bit 4 set (high nibbles)
  sum_t mem_a [DEPTH];
  sum_t mem_b [DEPTH];
  logic [DEPTH-1:0] vld_a_r;
  logic [DEPTH-1:0] vld_b_r;
  sum_t rd_a_r;
  sum_t rd_b_r;
  logic rd_vld_a_r;
  logic rd_vld_b_r;

  logic we_a;
  logic we_b;
  sum_t wd_a;
  sum_t wd_b;

  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[s1_addr_r] <= wd_a;
    end
    rd_a_r <= mem_a[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[s1_addr_r] <= wd_b;
    end
    rd_b_r <= mem_b[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= '0;
      vld_b_r <= '0;
    end else begin
      if (we_a) begin
        vld_a_r[s1_addr_r] <= 1'b1;
      end
      if (we_b) begin
        vld_b_r[s1_addr_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_vld_a_r <= vld_a_r[rd_addr];
    rd_vld_b_r <= vld_b_r[rd_addr];
  end

  // write made at the edge of this stage's read, forwarded when it hits the same entry
  logic              fwd_a_en_r;
  logic              fwd_b_en_r;
  logic [ADDR_W-1:0] fwd_addr_r;
  sum_t              fwd_a_data_r;
  sum_t              fwd_b_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_a_en_r <= 1'b0;
      fwd_b_en_r <= 1'b0;
    end else begin
      fwd_a_en_r <= we_a;
      fwd_b_en_r <= we_b;
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr_r   <= s1_addr_r;
    fwd_a_data_r <= wd_a;
    fwd_b_data_r <= wd_b;
  end

  sum_t cur_a;
  sum_t cur_b;

  always_comb begin
    if (fwd_a_en_r && (fwd_addr_r == s1_addr_r)) begin
      cur_a = fwd_a_data_r;
    end else if (rd_vld_a_r) begin
      cur_a = rd_a_r;
    end else begin
      cur_a = '0;
    end
    if (fwd_b_en_r && (fwd_addr_r == s1_addr_r)) begin
      cur_b = fwd_b_data_r;
    end else if (rd_vld_b_r) begin
      cur_b = rd_b_r;
    end else begin
      cur_b = '0;
    end
  end

  always_comb begin
    we_a = 1'b0;
    we_b = 1'b0;
    wd_a = sat_add(cur_a, s1_lo_r);
    wd_b = sat_add(cur_b, s1_hi_r);
    if (s1_valid_r) begin
      case (s1_func_r)
        FUNC_READ: begin
          // read and clear the selected entry
          we_a = !s1_bank_r;
          we_b = s1_bank_r;
          wd_a = '0;
          wd_b = '0;
        end
        default: begin
          we_a = s1_kok_r;
          we_b = s1_kok_r;
        end
      endcase
    end
  end

  logic s1_read_done;
  assign s1_read_done = s1_valid_r && (s1_func_r == FUNC_READ);

  logic out_valid_nxt;
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_read_done) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_read_done) begin
      out_index_r <= s1_sel_r;
      out_sum_r   <= s1_bank_r ? cur_b : cur_a;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-COL_W-SUM_W){1'b0}}, out_sum_r, out_index_r};

  // a finishing read always finds the output register free
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    s1_read_done |-> !out_valid_r)
    else $error("read result would overwrite a pending output word");

  // a read in flight holds off the next word
  a_read_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s1_read_done |-> !in_tready)
    else $error("input accepted while a read is in stage one");

  // every read gives exactly one result word next cycle
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_read_done |=> out_valid_r)
    else $error("read did not produce a result word");

  // forwarding only follows a real write from stage one
  a_fwd_src: assert property (@(posedge clk) disable iff (!rst_n)
    (fwd_a_en_r || fwd_b_en_r) |-> $past(s1_valid_r))
    else $error("forwarding flag without a preceding write");

endmodule

>>> tb/nwcs_column_sum_checker.sv
// checker for the nibble weight column sums unit: mirrors the column sums and checks each result word
`timescale 1ns / 1ps

module nwcs_column_sum_checker
  import nwcs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   cfg_wr_en,
  input  logic                   cfg_wr_data,      // number_format

  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,         // byte_offset, weight_byte, column_select, zeros
  input  logic                   in_tuser,         // func

  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,        // column_index, column_sum, zeros

  output int                     pending,
  output int                     mismatches
);

  typedef struct packed {
    logic [COL_W-1:0] index;
    sum_t             sum;
  } col_word_t;

  sum_t      column_sums [2*DEPTH];
  num_fmt_t  fmt;
  col_word_t sums_due [$];
  int        bad = 0;

  function automatic int weight_of(input num_fmt_t f, input logic [3:0] code);
    int mag;
    if (f == FMT_INT4) begin
      return int'(code) - (code[3] ? 16 : 0);
    end
    // fp4: magnitude from the low three bits, sign from the top bit
    case (code[2:0])
      3'd5:    mag = 6;
      3'd6:    mag = 8;
      3'd7:    mag = 12;
      default: mag = int'(code[2:0]);
    endcase
    return code[3] ? -mag : mag;
  endfunction

  function automatic sum_t clamped(input sum_t s, input int w);
    int t;
    t = int'(s) + w;
    if (t > int'(SUM_MAX)) begin
      t = int'(SUM_MAX);
    end else if (t < int'(SUM_MIN)) begin
      t = int'(SUM_MIN);
    end
    return sum_t'(t);
  endfunction

  task automatic accept_word(input logic [IN_TDATA_W-1:0] d, input func_t f);
    logic [OFF_W-1:0]  off;
    logic [BYTE_W-1:0] wb;
    logic [COL_W-1:0]  sel;
    logic [COL_W-1:0]  col;
    logic [5:0]        row;
    int                k;
    col_word_t         r;
    off = d[OFF_W-1:0];
    wb  = d[OFF_W +: BYTE_W];
    sel = d[OFF_W+BYTE_W +: COL_W];
    if (f == FUNC_READ) begin
      r.index = sel;
      r.sum   = column_sums[sel];
      sums_due.push_back(r);
      column_sums[sel] = '0;
    end else begin
      row = off[OFF_W-1:7];
      k   = int'(row[5:1]) * 4 + int'(off[1:0]);
      if (k < RED_LEN) begin
        // index b*64 + n: half, column group, nibble select, column within 16
        col = {row[0], off[6], 1'b0, off[5:2]};
        column_sums[col] = clamped(column_sums[col], weight_of(fmt, wb[3:0]));
        col[4] = 1'b1;
        column_sums[col] = clamped(column_sums[col], weight_of(fmt, wb[7:4]));
      end
    end
  endtask

  always @(posedge clk) begin : watch
    col_word_t        want;
    logic [COL_W-1:0] got_index;
    sum_t             got_sum;
    if (!rst_n) begin
      foreach (column_sums[i]) column_sums[i] = '0;
      fmt = FMT_INT4;
      sums_due.delete();
    end else begin
      if (cfg_wr_en) begin
        fmt = num_fmt_t'(cfg_wr_data);
      end
      if (in_tvalid && in_tready) begin
        accept_word(in_tdata, func_t'(in_tuser));
      end
      if (out_tvalid && out_tready) begin
        got_index = out_tdata[COL_W-1:0];
        got_sum   = out_tdata[COL_W +: SUM_W];
        if (sums_due.size() == 0) begin
          if (bad < 10) begin
            $display("%0t: result word with none due: column %0d sum %0d",
                     $realtime, got_index, $signed(got_sum));
          end
          bad++;
        end else begin
          want = sums_due.pop_front();
          if (want.index !== got_index || want.sum !== got_sum) begin
            if (bad < 10) begin
              $display("%0t: mismatch: expected column %0d sum %0d, got column %0d sum %0d",
                       $realtime, want.index, $signed(want.sum), got_index, $signed(got_sum));
            end
            bad++;
          end
        end
      end
    end
    pending    <= sums_due.size();
    mismatches <= bad;
  end

endmodule

>>> tb/nibble_weight_column_sums_unit_tb.sv
// top of the nibble weight column sums unit testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module nibble_weight_column_sums_unit_tb;
  import nwcs_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 80;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_ITEMS   = 1030;
  localparam int PHASES         = 6;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   cfg_wr_en   = 1'b0;
  logic                   cfg_wr_data = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic                   in_tuser    = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  logic       calm          = 1'b0;
  int         hold_reqs     = 0;
  int         holds_served  = 0;
  int         pending;
  int         mismatches;
  int         words_sent    = 0;
  int         reads_sent    = 0;
  int         format_writes = 0;
  int         stall_cycles  = 0;
  logic [1:0] formats_seen  = '0;

  always #5 clk = ~clk;

  nibble_weight_column_sums_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  nwcs_column_sum_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .pending     (pending),
    .mismatches  (mismatches)
  );

  // result side: random back-pressure, or a long hold when the stimulus asks for one
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_served) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_served <= holds_served + 1;
      end else begin
        out_tready <= calm || ($urandom_range(0, 99) >= 37);
      end
    end
  end

  initial begin : watchdog
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
    $display("nibble_weight_column_sums_unit_tb: done, errors");
    $finish;
  end

  task automatic send_word(input func_t f, input logic [OFF_W-1:0] off,
                           input logic [BYTE_W-1:0] wb, input logic [COL_W-1:0] sel);
    if (!calm) begin
      while ($urandom_range(0, 99) < 37) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= {{(IN_TDATA_W-OFF_W-BYTE_W-COL_W){1'b0}}, sel, wb, off};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
    if (f == FUNC_READ) begin
      reads_sent++;
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_format(input num_fmt_t f);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= f;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    format_writes++;
    formats_seen[f] = 1'b1;
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte();
    logic [BYTE_W-1:0] v;
    v = BYTE_W'($urandom);
    if ($urandom_range(0, 99) < 15) begin
      case ($urandom_range(0, 7))
        0:       v = 8'h00;
        1:       v = 8'hFF;
        2:       v = 8'h77;
        3:       v = 8'h88;
        4:       v = 8'h7F;
        5:       v = 8'hF7;
        6:       v = 8'h80;
        default: v = 8'h08;
      endcase
    end
    return v;
  endfunction

  // bytes of one column pair at random k, then read and clear both sums;
  // a fixed byte repeats offsets, so the sums clamp, and a few opposite bytes follow
  task automatic column_run(input int len, input int fixed);
    logic              b;
    logic              g;
    logic [3:0]        c;
    logic [4:0]        k_hi;
    logic [1:0]        k_lo;
    logic [BYTE_W-1:0] wb;
    logic [COL_W-1:0]  low_col;
    logic [OFF_W-1:0]  junk_off;
    logic [COL_W-1:0]  junk_sel;
    int                tail;
    b    = 1'($urandom_range(0, 1));
    g    = 1'($urandom_range(0, 1));
    c    = 4'($urandom_range(0, 15));
    tail = (fixed < 0) ? 0 : 3;
    for (int i = 0; i < len + tail; i++) begin
      k_hi     = 5'($urandom);
      k_lo     = 2'($urandom);
      junk_sel = COL_W'($urandom);
      if (fixed < 0) begin
        wb = pick_byte();
      end else if (i < len) begin
        wb = fixed[BYTE_W-1:0];
      end else begin
        wb = fixed[BYTE_W-1:0] ^ 8'h88;
      end
      send_word(FUNC_ACC, {k_hi, b, g, c, k_lo}, wb, junk_sel);
    end
    low_col = {b, g, 1'b0, c};
    for (int i = 0; i < 2; i++) begin
      junk_off = OFF_W'($urandom);
      send_word(FUNC_READ, junk_off, pick_byte(),
                low_col ^ COL_W'(($urandom_range(0, 1) ^ i) << 4));
    end
    if ($urandom_range(0, 4) == 0) begin
      junk_off = OFF_W'($urandom);
      send_word(FUNC_READ, junk_off, pick_byte(), low_col);
    end
  endtask

  task automatic noise_word();
    logic [OFF_W-1:0] off;
    logic [COL_W-1:0] sel;
    off = OFF_W'($urandom);
    sel = COL_W'($urandom);
    send_word(func_t'($urandom_range(0, 1)), off, pick_byte(), sel);
  endtask

  // receiver holds off while reads keep coming, so the block backs up its input
  task automatic stall_burst();
    logic [OFF_W-1:0] off;
    logic [COL_W-1:0] sel;
    hold_reqs <= hold_reqs + 1;
    calm      <= 1'b1;
    for (int i = 0; i < 16; i++) begin
      off = OFF_W'($urandom);
      sel = COL_W'($urandom);
      send_word(FUNC_READ, off, pick_byte(), sel);
    end
    calm <= 1'b0;
  endtask

  initial begin : stimulus
    int first_random;
    int goal;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_format(FMT_INT4);

    // int4: offset extremes, both halves, highest k, sign extremes of the nibbles
    send_word(FUNC_ACC,  13'd0,    8'h00, 7'd0);
    send_word(FUNC_ACC,  13'd0,    8'h87, 7'd127);
    send_word(FUNC_ACC,  13'd8191, 8'hFF, 7'd0);
    send_word(FUNC_ACC,  13'd8191, 8'h78, 7'd127);
    send_word(FUNC_ACC,  13'h0080, 8'h7F, 7'd0);
    send_word(FUNC_READ, 13'd8191, 8'hFF, 7'd0);
    send_word(FUNC_READ, 13'd0,    8'h00, 7'd16);
    send_word(FUNC_READ, 13'd0,    8'h00, 7'd111);
    send_word(FUNC_READ, 13'd0,    8'h00, 7'd127);
    // already cleared by the read before
    send_word(FUNC_READ, 13'd8191, 8'hFF, 7'd127);
    send_word(FUNC_READ, 13'd0,    8'h00, 7'd64);
    send_word(FUNC_READ, 13'd0,    8'h00, 7'd80);

    // fp4: every code once, positive codes land low, negative high
    set_format(FMT_FP4);
    send_word(FUNC_ACC,  13'h1abc, 8'h80, 7'd0);
    send_word(FUNC_ACC,  13'h1abc, 8'h91, 7'd0);
    send_word(FUNC_ACC,  13'h1abc, 8'hA2, 7'd0);
    send_word(FUNC_ACC,  13'h1abc, 8'hB3, 7'd0);
    send_word(FUNC_ACC,  13'h1abc, 8'hC4, 7'd0);
    send_word(FUNC_ACC,  13'h1abc, 8'hD5, 7'd0);
    send_word(FUNC_ACC,  13'h1abc, 8'hE6, 7'd0);
    send_word(FUNC_ACC,  13'h1abc, 8'hF7, 7'd0);
    send_word(FUNC_READ, 13'd0,    8'h00, 7'd79);
    send_word(FUNC_READ, 13'd0,    8'h00, 7'd95);

    first_random = words_sent;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0, 2:    set_format(FMT_FP4);
        1, 4:    set_format(FMT_INT4);
        default: set_format(num_fmt_t'($urandom_range(0, 1)));
      endcase
      if (phase == 4) begin
        calm <= 1'b1;
      end
      if (phase == 0) begin
        column_run(185, 8'h77);
      end else if (phase == 2) begin
        column_run(185, 8'hFF);
      end else if (phase == 1) begin
        stall_burst();
      end
      goal = first_random + (phase + 1) * RANDOM_ITEMS / PHASES;
      while (words_sent < goal) begin
        if ($urandom_range(0, 99) < 70) begin
          column_run($urandom_range(1, 20), -1);
        end else begin
          noise_word();
        end
      end
      if (phase == 4) begin
        calm <= 1'b0;
      end
    end

    wait_drained();
    @(negedge clk);
    $display("covered %0d words (%0d read-and-clear) over %0d format writes, formats seen %b",
             words_sent, reads_sent, format_writes, formats_seen);
    $display("clamping runs at both limits and a long result-side stall were included");
    if (mismatches == 0 && pending == 0) begin
      $display("nibble_weight_column_sums_unit_tb: done, clean");
    end else begin
      $display("nibble_weight_column_sums_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
